// ===== hdl/wpm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package wpm_pkg;

  localparam int unsigned CHAR_W = 21;

  localparam logic [CHAR_W-1:0] CHAR_STAR = 21'd42;
  localparam logic [CHAR_W-1:0] CHAR_ANY  = 21'd63;

  typedef enum logic [1:0] {
    FUNC_APPEND    = 2'd0,
    FUNC_CLEAR     = 2'd1,
    FUNC_SUBJECT   = 2'd2,
    FUNC_EMPTY_END = 2'd3
  } func_e;

  typedef struct packed {
    func_e             func;
    logic [CHAR_W-1:0] character;
    logic              last_char;
  } in_t;

  typedef struct packed {
    logic matched;
    logic pattern_overflow;
  } out_t;

  // Commands to the pattern store.
  typedef struct packed {
    logic append;
    logic clear;
  } pat_cmd_t;

  // Commands to the position automaton.
  typedef struct packed {
    logic step;
    logic empty_end;
    logic abandon;
    logic last;
  } match_cmd_t;

endpackage

`default_nettype wire

// ===== hdl/wildcard_pattern_matcher.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Wildcard pattern matcher, case sensitive.
// Input beats on in_*: func selects append pattern character, clear pattern,
// subject character or end of an empty subject. '?' matches one character,
// '*' any run. Output beats on out_* carry matched and pattern_overflow; one
// beat follows each subject character flagged last_char and each empty
// subject end, no beat follows anything else.
// An accepted beat lands in the input register; its result, evaluated against
// the pattern and position set, goes to the output register shown on out_*.
// Throughput: one input beat per cycle unless a result beat waits for the
// output register; the position set is updated by one comparator per pattern
// position and one carry chain of MAX_PATTERN+1 bits.
// Reset empties the pattern, clears the overflow flag and ends any subject;
// it takes effect at once, no sweep follows.
// When the receiver stalls with a result held, beats keep moving into the
// input register; a beat that produces a result then waits there and
// in_ready_o drops until the output register frees.
module wildcard_pattern_matcher #(
  parameter int unsigned MAX_PATTERN = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire wpm_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output wpm_pkg::out_t      out_data_o
);
  import wpm_pkg::*;

  localparam int unsigned LEN_W = $clog2(MAX_PATTERN + 1);

  logic       s1_valid_q;
  in_t        s1_q;
  logic       out_valid_q;
  out_t       out_q;
  logic       gives_result;
  logic       out_free;
  logic       s1_go;
  pat_cmd_t   pat_cmd;
  match_cmd_t match_cmd;

  logic [MAX_PATTERN-1:0] star;
  logic [MAX_PATTERN-1:0] hit;
  logic [MAX_PATTERN:0]   lead;
  logic [LEN_W-1:0]       len;
  logic                   overflow;
  logic                   matched_raw;

  assign gives_result = ((s1_q.func == FUNC_SUBJECT) && s1_q.last_char) ||
                        (s1_q.func == FUNC_EMPTY_END);
  assign out_free     = !out_valid_q || out_ready_i;
  assign s1_go        = s1_valid_q && (!gives_result || out_free);
  assign in_ready_o   = !s1_valid_q || s1_go;

  always_comb begin
    pat_cmd.append      = s1_go && (s1_q.func == FUNC_APPEND);
    pat_cmd.clear       = s1_go && (s1_q.func == FUNC_CLEAR);
    match_cmd.step      = s1_go && (s1_q.func == FUNC_SUBJECT);
    match_cmd.empty_end = s1_go && (s1_q.func == FUNC_EMPTY_END);
    match_cmd.abandon   = pat_cmd.append || pat_cmd.clear;
    match_cmd.last      = s1_q.last_char;
  end

  wpm_pattern #(
    .MAX_PATTERN (MAX_PATTERN),
    .LEN_W       (LEN_W)
  ) u_pattern (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (pat_cmd),
    .character_i (s1_q.character),
    .star_o      (star),
    .hit_o       (hit),
    .lead_o      (lead),
    .len_o       (len),
    .overflow_o  (overflow)
  );

  wpm_matcher #(
    .MAX_PATTERN (MAX_PATTERN),
    .LEN_W       (LEN_W)
  ) u_matcher (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (match_cmd),
    .star_i    (star),
    .hit_i     (hit),
    .lead_i    (lead),
    .len_i     (len),
    .matched_o (matched_raw)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s1_go && gives_result) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers: hold unless a new beat moves in
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_q <= in_data_i;
    end
    if (s1_go && gives_result) begin
      out_q.matched          <= matched_raw && !overflow;
      out_q.pattern_overflow <= overflow;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== hdl/wpm_pattern.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wpm_pattern #(
  parameter int unsigned MAX_PATTERN = 32,
  parameter int unsigned LEN_W       = 6
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire wpm_pkg::pat_cmd_t          cmd_i,
  input  wire logic [wpm_pkg::CHAR_W-1:0] character_i,
  output logic [MAX_PATTERN-1:0]          star_o,
  output logic [MAX_PATTERN-1:0]          hit_o,
  output logic [MAX_PATTERN:0]            lead_o,
  output logic [LEN_W-1:0]                len_o,
  output logic                            overflow_o
);
  import wpm_pkg::*;

  localparam int unsigned IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam logic [LEN_W-1:0] FULL = LEN_W'(MAX_PATTERN);

  logic [CHAR_W-1:0] store_q [MAX_PATTERN];
  logic [LEN_W-1:0]  len_q, len_d;
  logic              ovf_q, ovf_d;
  logic [MAX_PATTERN:0] lead_q, lead_d;
  logic              room;

  assign room = (len_q < FULL);

  always_ff @(posedge clk_i) begin
    if (cmd_i.append && room) begin
      store_q[len_q[IDX_W-1:0]] <= character_i;
    end
  end

  always_comb begin
    len_d  = len_q;
    ovf_d  = ovf_q;
    lead_d = lead_q;
    if (cmd_i.clear) begin
      len_d  = '0;
      ovf_d  = 1'b0;
      lead_d = {{MAX_PATTERN{1'b0}}, 1'b1};
    end else if (cmd_i.append) begin
      if (room) begin
        len_d = len_q + LEN_W'(1);
        // extend the leading star run that the start set covers
        if (character_i == CHAR_STAR && lead_q[len_q]) begin
          lead_d[len_d] = 1'b1;
        end
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      ovf_q  <= 1'b0;
      lead_q <= {{MAX_PATTERN{1'b0}}, 1'b1};
    end else begin
      len_q  <= len_d;
      ovf_q  <= ovf_d;
      lead_q <= lead_d;
    end
  end

  // One comparator lane per pattern position; lanes past the length are off.
  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      star_o[i] = (LEN_W'(i) < len_q) && (store_q[i] == CHAR_STAR);
      hit_o[i]  = (LEN_W'(i) < len_q) &&
                  ((store_q[i] == CHAR_ANY) || (store_q[i] == character_i));
    end
  end

  assign lead_o     = lead_q;
  assign len_o      = len_q;
  assign overflow_o = ovf_q;

endmodule

`default_nettype wire

// ===== hdl/wpm_matcher.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wpm_matcher #(
  parameter int unsigned MAX_PATTERN = 32,
  parameter int unsigned LEN_W       = 6
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire wpm_pkg::match_cmd_t     cmd_i,
  input  wire logic [MAX_PATTERN-1:0]  star_i,
  input  wire logic [MAX_PATTERN-1:0]  hit_i,
  input  wire logic [MAX_PATTERN:0]    lead_i,
  input  wire logic [LEN_W-1:0]        len_i,
  output logic                         matched_o
);
  import wpm_pkg::*;

  localparam int unsigned N = MAX_PATTERN;

  logic [N:0]   active_q, active_d;
  logic         started_q, started_d;
  logic [N:0]   cur;
  logic [N:0]   gen;
  logic [N:0]   prop;
  logic [N:0]   op_a;
  logic [N+1:0] sum;
  logic [N+1:0] carry_in;
  logic [N:0]   closed;

  always_comb begin
    cur = started_q ? active_q : lead_i;
    // stay on a star, step past a matching character
    gen  = {1'b0, cur[N-1:0] & star_i} | {cur[N-1:0] & ~star_i & hit_i, 1'b0};
    // star closure as a carry chain: a star at j passes activity to j+1
    prop = {star_i, 1'b0};
    op_a = gen | prop;
    sum      = {1'b0, op_a} + {1'b0, gen};
    carry_in = sum ^ {1'b0, op_a} ^ {1'b0, gen};
    closed   = carry_in[N+1:1];
  end

  always_comb begin
    active_d  = active_q;
    started_d = started_q;
    if (cmd_i.abandon || cmd_i.empty_end) begin
      started_d = 1'b0;
    end else if (cmd_i.step) begin
      active_d  = closed;
      started_d = !cmd_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= '0;
      started_q <= 1'b0;
    end else begin
      active_q  <= active_d;
      started_q <= started_d;
    end
  end

  assign matched_o = cmd_i.empty_end ? lead_i[len_i] : closed[len_i];

endmodule

`default_nettype wire

// ===== verif/wpm_checker.sv =====
`timescale 1ns / 1ps

module wpm_checker #(
  parameter int unsigned MAX_PATTERN = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_ready_i,
  input  wpm_pkg::in_t  in_data_i,
  input  logic          out_valid_i,
  input  logic          out_ready_i,
  input  wpm_pkg::out_t out_data_i,
  output int            fail_count_o,
  output int            pending_o,
  output int            beat_count_o,
  output int            result_count_o,
  output int            match_count_o,
  output int            overflow_count_o
);
  import wpm_pkg::*;

  // Mirror of the matcher: pattern, live position set, subject and overflow flags.
  logic [CHAR_W-1:0]    pat_mem [MAX_PATTERN];
  int unsigned          pat_len;
  logic [MAX_PATTERN:0] live;
  logic                 in_subject;
  logic                 ovf;
  out_t                 verdict_q [$];

  // A star at a live position also makes the position after it live.
  function automatic logic [MAX_PATTERN:0] spread_stars(input logic [MAX_PATTERN:0] s);
    logic [MAX_PATTERN:0] r;
    r = s;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (i < pat_len && r[i] && pat_mem[i] == CHAR_STAR) r[i+1] = 1'b1;
    end
    return r;
  endfunction

  function automatic logic [MAX_PATTERN:0] fresh_set();
    logic [MAX_PATTERN:0] s;
    s = '0;
    s[0] = 1'b1;
    return spread_stars(s);
  endfunction

  function automatic void step_char(input logic [CHAR_W-1:0] ch);
    logic [MAX_PATTERN:0] nxt;
    nxt = '0;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (i < pat_len && live[i]) begin
        if (pat_mem[i] == CHAR_STAR) nxt[i] = 1'b1;
        else if (pat_mem[i] == CHAR_ANY || pat_mem[i] == ch) nxt[i+1] = 1'b1;
      end
    end
    live = spread_stars(nxt);
  endfunction

  function automatic out_t settle();
    out_t r;
    r.matched          = live[pat_len] & ~ovf;
    r.pattern_overflow = ovf;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      pat_len    = 0;
      live       = '0;
      in_subject = 1'b0;
      ovf        = 1'b0;
      verdict_q.delete();
      pending_o  = 0;
    end else begin
      // Retire the result beat first; a beat accepted now cannot answer this edge.
      if (out_valid_i && out_ready_i) begin
        if (verdict_q.size() == 0) begin
          $error("result beat with none expected: matched %0b, pattern_overflow %0b",
                 out_data_i.matched, out_data_i.pattern_overflow);
          fail_count_o++;
        end else begin
          want = verdict_q.pop_front();
          if (out_data_i.matched !== want.matched) begin
            $error("matched: expected %0b, got %0b", want.matched, out_data_i.matched);
            fail_count_o++;
          end
          if (out_data_i.pattern_overflow !== want.pattern_overflow) begin
            $error("pattern_overflow: expected %0b, got %0b",
                   want.pattern_overflow, out_data_i.pattern_overflow);
            fail_count_o++;
          end
          result_count_o++;
          if (want.matched) match_count_o++;
          if (want.pattern_overflow) overflow_count_o++;
        end
      end
      if (in_valid_i && in_ready_i) begin
        beat_count_o++;
        case (in_data_i.func)
          FUNC_APPEND: begin
            in_subject = 1'b0;
            if (pat_len < MAX_PATTERN) begin
              pat_mem[pat_len] = in_data_i.character;
              pat_len++;
            end else begin
              ovf = 1'b1;
            end
          end
          FUNC_CLEAR: begin
            in_subject = 1'b0;
            pat_len    = 0;
            ovf        = 1'b0;
          end
          FUNC_SUBJECT: begin
            if (!in_subject) begin
              live       = fresh_set();
              in_subject = 1'b1;
            end
            step_char(in_data_i.character);
            if (in_data_i.last_char) begin
              in_subject = 1'b0;
              verdict_q.push_back(settle());
            end
          end
          FUNC_EMPTY_END: begin
            live       = fresh_set();
            in_subject = 1'b0;
            verdict_q.push_back(settle());
          end
        endcase
      end
      pending_o = verdict_q.size();
    end
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import wpm_pkg::*;

  localparam int unsigned MAX_PATTERN  = 32;
  localparam int          TOTAL_BEATS  = 1025;
  localparam int          LONG_HOLD    = 300;
  localparam logic [CHAR_W-1:0] CH_A   = 21'd97;
  localparam logic [CHAR_W-1:0] CH_B   = 21'd98;
  localparam logic [CHAR_W-1:0] CH_C   = 21'd99;
  localparam logic [CHAR_W-1:0] CH_X   = 21'd120;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  int fails;
  int pending;
  int beats;
  int results;
  int match_total;
  int overflows;

  int   sent;
  int   taken;
  logic rush;
  logic hold_out;

  logic [CHAR_W-1:0] pat_q [$];
  logic [CHAR_W-1:0] subj_q [$];

  initial clk = 1'b0;
  always #4 clk = ~clk;

  wildcard_pattern_matcher #(
    .MAX_PATTERN (MAX_PATTERN)
  ) DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  wpm_checker #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_data_i       (out_data),
    .fail_count_o     (fails),
    .pending_o        (pending),
    .beat_count_o     (beats),
    .result_count_o   (results),
    .match_count_o    (match_total),
    .overflow_count_o (overflows)
  );

  function automatic logic [CHAR_W-1:0] rand_char();
    return CHAR_W'($urandom());
  endfunction

  function automatic logic [CHAR_W-1:0] pick_pat_char();
    case ($urandom_range(0, 9))
      0, 1:    return CHAR_STAR;
      2, 3:    return CHAR_ANY;
      4:       return rand_char();
      default: return CH_A + CHAR_W'($urandom_range(0, 2));
    endcase
  endfunction

  // Offer one beat and hold it until taken.
  task automatic send_beat(input func_e f, input logic [CHAR_W-1:0] ch, input logic last);
    in_t beat;
    int  gap;
    beat.func      = f;
    beat.character = ch;
    beat.last_char = last;
    gap = (rush || (sent / 64) % 3 == 2) ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic load_pattern();
    send_beat(FUNC_CLEAR, rand_char(), 1'($urandom_range(0, 1)));
    foreach (pat_q[i]) send_beat(FUNC_APPEND, pat_q[i], 1'($urandom_range(0, 1)));
  endtask

  task automatic send_subject();
    if (subj_q.size() == 0) begin
      send_beat(FUNC_EMPTY_END, rand_char(), 1'($urandom_range(0, 1)));
    end else begin
      foreach (subj_q[i]) send_beat(FUNC_SUBJECT, subj_q[i], i == subj_q.size() - 1);
    end
  endtask

  // Receiver: random stall per result, quiet stretches, one long hold-off.
  initial begin
    int stall;
    out_ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_out) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_out = 1'b0;
      end
      stall = ((taken / 40) % 3 == 1) ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
    end
  end

  initial begin
    int   len;
    int   drain;
    logic held;
    rush     = 1'b0;
    hold_out = 1'b0;
    held     = 1'b0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty pattern: only the empty subject matches.
    send_beat(FUNC_EMPTY_END, '0, 1'b0);
    send_beat(FUNC_SUBJECT, CH_A, 1'b1);
    // Star run, literal and single wildcard.
    pat_q = '{CHAR_STAR, CHAR_STAR, CH_A, CHAR_ANY};
    foreach (pat_q[i]) send_beat(FUNC_APPEND, pat_q[i], 1'b0);
    subj_q = '{CH_X, CH_A, CH_B};
    send_subject();
    send_beat(FUNC_EMPTY_END, '1, 1'b1);
    // Append in the middle of a subject drops that subject.
    send_beat(FUNC_SUBJECT, CH_A, 1'b0);
    send_beat(FUNC_APPEND, CHAR_ANY, 1'b0);
    subj_q = '{CH_A, CH_B, CH_C};
    send_subject();
    // Extreme character codes.
    send_beat(FUNC_CLEAR, '0, 1'b0);
    send_beat(FUNC_APPEND, '1, 1'b1);
    send_beat(FUNC_SUBJECT, '1, 1'b1);
    send_beat(FUNC_SUBJECT, '0, 1'b1);
    // The end of the pattern does not absorb extra characters.
    pat_q = '{CH_A};
    load_pattern();
    subj_q = '{CH_A, CH_B};
    send_subject();
    send_beat(FUNC_SUBJECT, CH_A, 1'b1);

    while (sent < TOTAL_BEATS) begin
      if (!held && sent > 500) begin
        // Flood results while the receiver holds off so the input side backs up.
        held     = 1'b1;
        hold_out = 1'b1;
        rush     = 1'b1;
        pat_q    = '{CHAR_STAR};
        load_pattern();
        repeat (24) send_beat(FUNC_SUBJECT, rand_char(), 1'b1);
        rush = 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 8))
          send_beat(func_e'($urandom_range(0, 3)), rand_char(), 1'($urandom_range(0, 1)));
      end else begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(28, 35) : $urandom_range(0, 8);
        pat_q.delete();
        repeat (len) pat_q.push_back(pick_pat_char());
        load_pattern();
        repeat ($urandom_range(1, 4)) begin
          subj_q.delete();
          if ($urandom_range(0, 1)) begin
            // Instantiate the pattern, sometimes with one character spoiled.
            foreach (pat_q[i]) begin
              if (pat_q[i] == CHAR_STAR)
                repeat ($urandom_range(0, 3)) subj_q.push_back(CH_A + CHAR_W'($urandom_range(0, 2)));
              else if (pat_q[i] == CHAR_ANY)
                subj_q.push_back(($urandom_range(0, 3) == 0) ? rand_char()
                                 : CH_A + CHAR_W'($urandom_range(0, 2)));
              else
                subj_q.push_back(pat_q[i]);
            end
            if ($urandom_range(0, 3) == 0 && subj_q.size() > 0)
              subj_q[$urandom_range(0, subj_q.size() - 1)] = CH_C;
          end else begin
            repeat ($urandom_range(0, 8))
              subj_q.push_back(($urandom_range(0, 7) == 0) ? rand_char()
                               : CH_A + CHAR_W'($urandom_range(0, 2)));
          end
          if ($urandom_range(0, 7) == 0 && subj_q.size() > 1) begin
            // Cut the subject short, then disturb it.
            repeat ($urandom_range(1, subj_q.size() - 1))
              send_beat(FUNC_SUBJECT, subj_q.pop_front(), 1'b0);
            if ($urandom_range(0, 1)) begin
              pat_q.push_back(pick_pat_char());
              send_beat(FUNC_APPEND, pat_q[$], 1'b0);
            end else begin
              send_beat(FUNC_EMPTY_END, rand_char(), 1'b0);
            end
          end else begin
            send_subject();
          end
        end
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    drain = 0;
    while (pending != 0 && drain < 5000) begin
      @(posedge clk);
      drain++;
    end
    repeat (10) @(posedge clk);
    $display("Run covered %0d input beats and %0d results", beats, results);
    $display("  %0d matched, %0d with pattern overflow", match_total, overflows);
    if (fails == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
